// File: rtl/rsa_pkg.sv
// rsa_pkg: shared types and constants for the saturation adjust pipeline.
// No dependencies; used by every module of the block.
package rsa_pkg;

  localparam int PIX_W     = 8;    // one colour channel
  localparam int LSUM_W    = 9;    // max + min
  localparam int SAT_FULL  = 100;  // full-scale increment
  localparam int L_SPAN    = 510;  // 2 * 255
  localparam int RCP_SHIFT = 24;   // reciprocal scale, 2^24
  localparam int RCP_W     = 25;   // holds 2^24 for a divisor of one
  localparam int QX_W      = 16;   // halved magnitude of the scaled offset
  localparam int DEN_N     = 256;  // divisor table depth

  typedef struct packed {
    logic [PIX_W-1:0] channel_a_in;
    logic [PIX_W-1:0] channel_b_in;
    logic [PIX_W-1:0] channel_c_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] channel_a_out;
    logic [PIX_W-1:0] channel_b_out;
    logic [PIX_W-1:0] channel_c_out;
  } out_item_t;

  // per-stage load enables, s1 nearest the input
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } stage_en_t;

endpackage

// File: rtl/rsa_factor.sv
// rsa_factor: stages 1 and 2 - pixel extremes, then gain numerator/denominator.
// Depends on rsa_pkg.
module rsa_factor (
  input  logic                             clk,
  input  rsa_pkg::stage_en_t               en,
  input  rsa_pkg::in_item_t                in_data,
  input  logic signed [rsa_pkg::PIX_W-1:0] sat_inc,
  output logic [rsa_pkg::PIX_W-1:0]        t_a,
  output logic [rsa_pkg::PIX_W-1:0]        t_b,
  output logic [rsa_pkg::PIX_W-1:0]        t_c,
  output logic [rsa_pkg::LSUM_W-1:0]       lsum,
  output logic [rsa_pkg::PIX_W-1:0]        num,
  output logic [rsa_pkg::PIX_W-1:0]        den,
  output logic                             bypass
);

  localparam int PW = rsa_pkg::PIX_W;
  localparam int LW = rsa_pkg::LSUM_W;

  // stage 1
  logic [PW-1:0] mn, mx, mn_ab, mx_ab;
  logic [LW-1:0] l_sum, l_rev;
  logic [PW-1:0] s1_a_r, s1_b_r, s1_c_r;
  logic [PW-1:0] s1_delta_r, s1_m_r;
  logic [LW-1:0] s1_lsum_r;

  always_comb begin
    mn_ab = (in_data.channel_b_in < in_data.channel_a_in) ?
            in_data.channel_b_in : in_data.channel_a_in;
    mx_ab = (in_data.channel_b_in > in_data.channel_a_in) ?
            in_data.channel_b_in : in_data.channel_a_in;
    mn    = (in_data.channel_c_in < mn_ab) ? in_data.channel_c_in : mn_ab;
    mx    = (in_data.channel_c_in > mx_ab) ? in_data.channel_c_in : mx_ab;
    l_sum = {1'b0, mx} + {1'b0, mn};
    l_rev = LW'(rsa_pkg::L_SPAN) - l_sum;
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      s1_a_r     <= in_data.channel_a_in;
      s1_b_r     <= in_data.channel_b_in;
      s1_c_r     <= in_data.channel_c_in;
      s1_delta_r <= mx - mn;
      s1_lsum_r  <= l_sum;
      s1_m_r     <= (l_sum < l_rev) ? l_sum[PW-1:0] : l_rev[PW-1:0];
    end
  end

  // stage 2: 100*delta against (100-inc)*m picks the gain ratio
  logic        [14:0]   prod_d;
  logic signed [8:0]    gap;
  logic signed [17:0]   prod_m;
  logic                 first_br;
  logic [PW-1:0]        t_a_r, t_b_r, t_c_r, num_r, den_r;
  logic [LW-1:0]        lsum_r;
  logic                 bypass_r;

  always_comb begin
    prod_d   = 15'(rsa_pkg::SAT_FULL) * {7'd0, s1_delta_r};
    gap      = 9'sd100 - {sat_inc[PW-1], sat_inc};
    prod_m   = {{9{gap[8]}}, gap} * $signed({10'd0, s1_m_r});
    first_br = $signed({3'b000, prod_d}) >= prod_m;
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      t_a_r    <= s1_a_r;
      t_b_r    <= s1_b_r;
      t_c_r    <= s1_c_r;
      lsum_r   <= s1_lsum_r;
      num_r    <= first_br ? (s1_m_r - s1_delta_r) : sat_inc[PW-1:0];
      den_r    <= first_br ? s1_delta_r : gap[PW-1:0];
      bypass_r <= (sat_inc <= 8'sd0) || (s1_delta_r == '0);
    end
  end

  assign t_a    = t_a_r;
  assign t_b    = t_b_r;
  assign t_c    = t_c_r;
  assign lsum   = lsum_r;
  assign num    = num_r;
  assign den    = den_r;
  assign bypass = bypass_r;

endmodule

// File: rtl/rsa_recip.sv
// rsa_recip: constant reciprocal table, floor(2^24 / den), for the divider.
// Depends on rsa_pkg.
module rsa_recip (
  input  logic [rsa_pkg::PIX_W-1:0] den,
  output logic [rsa_pkg::RCP_W-1:0] rcp
);

  localparam int RW = rsa_pkg::RCP_W;

  logic [RW-1:0] rcp_tab [rsa_pkg::DEN_N];

  for (genvar gi = 0; gi < rsa_pkg::DEN_N; gi++) begin : g_tab
    // a zero divisor only occurs on bypassed items
    localparam logic [RW-1:0] RC =
      RW'((64'd1 << rsa_pkg::RCP_SHIFT) / ((gi == 0) ? 1 : gi));
    assign rcp_tab[gi] = RC;
  end

  assign rcp = rcp_tab[den];

endmodule

// File: rtl/rsa_chan.sv
// rsa_chan: stages 3 to 6 for one channel - scaled offset, reciprocal divide,
// floor correction and clamp. Depends on rsa_pkg.
module rsa_chan (
  input  logic                        clk,
  input  rsa_pkg::stage_en_t          en,
  input  logic [rsa_pkg::PIX_W-1:0]   t,
  input  logic [rsa_pkg::LSUM_W-1:0]  lsum,
  input  logic [rsa_pkg::PIX_W-1:0]   num,
  input  logic [rsa_pkg::PIX_W-1:0]   den,
  input  logic [rsa_pkg::RCP_W-1:0]   rcp,
  input  logic                        bypass,
  output logic [rsa_pkg::PIX_W-1:0]   result
);

  localparam int PW = rsa_pkg::PIX_W;
  localparam int QW = rsa_pkg::QX_W;
  localparam int RW = rsa_pkg::RCP_W;
  localparam int SH = rsa_pkg::RCP_SHIFT;

  // stage 3: e = (2t - L) * num, split into sign, |e|/2 and its odd bit
  logic signed [9:0]  dev;
  logic signed [18:0] e;
  logic [18:0]        e_mag;
  logic [QW-1:0]      s3_x_r;
  logic               s3_odd_r, s3_neg_r, s3_byp_r;
  logic [PW-1:0]      s3_t_r, s3_den_r;
  logic [RW-1:0]      s3_rcp_r;

  always_comb begin
    dev   = $signed({1'b0, t, 1'b0}) - $signed({1'b0, lsum});
    e     = {{9{dev[9]}}, dev} * $signed({11'd0, num});
    e_mag = e[18] ? 19'(-e) : e;
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      s3_x_r   <= e_mag[QW:1];
      s3_odd_r <= e_mag[0];
      s3_neg_r <= e[18];
      s3_byp_r <= bypass;
      s3_t_r   <= t;
      s3_den_r <= den;
      s3_rcp_r <= rcp;
    end
  end

  // stage 4: quotient estimate, low by at most one
  logic [QW+RW-1:0] prod;
  logic [QW-1:0]    s4_q_r, s4_x_r;
  logic             s4_odd_r, s4_neg_r, s4_byp_r;
  logic [PW-1:0]    s4_t_r, s4_den_r;

  assign prod = {{RW{1'b0}}, s3_x_r} * {{QW{1'b0}}, s3_rcp_r};

  always_ff @(posedge clk) begin
    if (en.s4) begin
      s4_q_r   <= prod[SH+QW-1:SH];
      s4_x_r   <= s3_x_r;
      s4_odd_r <= s3_odd_r;
      s4_neg_r <= s3_neg_r;
      s4_byp_r <= s3_byp_r;
      s4_t_r   <= s3_t_r;
      s4_den_r <= s3_den_r;
    end
  end

  // stage 5: remainder, one-step correction
  logic [QW+PW-1:0] qd;
  logic [QW-1:0]    rem, rem_fix;
  logic             fix;
  logic [QW-1:0]    s5_q_r;
  logic             s5_rnz_r, s5_neg_r, s5_byp_r;
  logic [PW-1:0]    s5_t_r;

  always_comb begin
    qd      = {{PW{1'b0}}, s4_q_r} * {{QW{1'b0}}, s4_den_r};
    rem     = s4_x_r - qd[QW-1:0];
    fix     = rem >= {{(QW-PW){1'b0}}, s4_den_r};
    rem_fix = fix ? rem - {{(QW-PW){1'b0}}, s4_den_r} : rem;
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      s5_q_r   <= s4_q_r + {{(QW-1){1'b0}}, fix};
      s5_rnz_r <= (rem_fix != '0) || s4_odd_r;
      s5_neg_r <= s4_neg_r;
      s5_byp_r <= s4_byp_r;
      s5_t_r   <= s4_t_r;
    end
  end

  // stage 6: floor towards minus infinity, add to channel, clamp
  logic        [QW:0]   q_mag;
  logic signed [QW+1:0] q_s, sum;
  logic [PW-1:0]        clamped;
  logic [PW-1:0]        res_r;

  always_comb begin
    q_mag = {1'b0, s5_q_r} + {{QW{1'b0}}, s5_neg_r & s5_rnz_r};
    q_s   = s5_neg_r ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    sum   = q_s + $signed({{(QW+2-PW){1'b0}}, s5_t_r});
    if (sum[QW+1]) begin
      clamped = '0;
    end else if (sum[QW:PW] != '0) begin
      clamped = '1;
    end else begin
      clamped = sum[PW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s6) begin
      res_r <= s5_byp_r ? s5_t_r : clamped;
    end
  end

  assign result = res_r;

endmodule

// File: rtl/rgb_saturation_adjust.sv
// rgb_saturation_adjust: top level of the pixel saturation boost pipeline.
// Depends on rsa_pkg, rsa_factor, rsa_recip and rsa_chan.
//
// Usage
//   Input channel  : in_valid / in_stall / in_data, one pixel (three 8-bit
//                    channels) per item.
//   Output channel : out_valid / out_stall / out_data, one adjusted pixel per
//                    item, in input order.
//   Config         : cfg_wr_en / cfg_wr_data write the signed saturation
//                    increment; write it only with the pipe empty.
//   Stages         : six register stages, s1 to s6; out_valid is the valid
//                    bit of stage 6.
//   Throughput     : 1 item per cycle while out_stall is low; every stage is
//                    a register with its own valid bit, and the narrowest step
//                    is the 16x25 reciprocal multiply in stage 4.
//   Reset          : rst_n (sync, active low) empties the pipe and clears
//                    the increment to zero, i.e. pixels pass unchanged.
//   Stall          : out_stall holds the output register; upstream stages
//                    keep filling bubbles and in_stall rises only once the
//                    stage ahead of the input is full and cannot move.
module rgb_saturation_adjust (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  rsa_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output rsa_pkg::out_item_t              out_data,
  input  logic                            cfg_wr_en,
  input  logic [rsa_pkg::PIX_W-1:0]       cfg_wr_data
);

  localparam int PW = rsa_pkg::PIX_W;

  // saturation increment register
  logic signed [PW-1:0] sat_inc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_inc_r <= '0;
    end else if (cfg_wr_en) begin
      sat_inc_r <= $signed(cfg_wr_data);
    end
  end

  // valid bits, one per stage; a stage loads when empty or when it drains
  logic [6:1] vld_r, vld_nxt;
  logic [6:1] adv;
  rsa_pkg::stage_en_t en;

  always_comb begin
    adv[6] = !vld_r[6] || !out_stall;
    for (int k = 5; k >= 1; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
    vld_nxt[1] = adv[1] ? in_valid : vld_r[1];
    for (int k = 2; k <= 6; k++) begin
      vld_nxt[k] = adv[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign en.s1 = adv[1];
  assign en.s2 = adv[2];
  assign en.s3 = adv[3];
  assign en.s4 = adv[4];
  assign en.s5 = adv[5];
  assign en.s6 = adv[6];

  assign in_stall  = !adv[1];
  assign out_valid = vld_r[6];

  // stages 1-2: extremes and gain ratio
  logic [PW-1:0]                 t_a, t_b, t_c, num, den;
  logic [rsa_pkg::LSUM_W-1:0]    lsum;
  logic                          bypass;
  logic [rsa_pkg::RCP_W-1:0]     rcp;

  rsa_factor u_factor (
    .clk     (clk),
    .en      (en),
    .in_data (in_data),
    .sat_inc (sat_inc_r),
    .t_a     (t_a),
    .t_b     (t_b),
    .t_c     (t_c),
    .lsum    (lsum),
    .num     (num),
    .den     (den),
    .bypass  (bypass)
  );

  // one reciprocal shared by all three channels
  rsa_recip u_recip (
    .den (den),
    .rcp (rcp)
  );

  // stages 3-6, one lane per channel; stage 6 is the output register
  rsa_chan u_chan_a (
    .clk    (clk),
    .en     (en),
    .t      (t_a),
    .lsum   (lsum),
    .num    (num),
    .den    (den),
    .rcp    (rcp),
    .bypass (bypass),
    .result (out_data.channel_a_out)
  );

  rsa_chan u_chan_b (
    .clk    (clk),
    .en     (en),
    .t      (t_b),
    .lsum   (lsum),
    .num    (num),
    .den    (den),
    .rcp    (rcp),
    .bypass (bypass),
    .result (out_data.channel_b_out)
  );

  rsa_chan u_chan_c (
    .clk    (clk),
    .en     (en),
    .t      (t_c),
    .lsum   (lsum),
    .num    (num),
    .den    (den),
    .rcp    (rcp),
    .bypass (bypass),
    .result (out_data.channel_c_out)
  );

endmodule

// File: test/tb_rgb_saturation_adjust.sv
// tb_rgb_saturation_adjust: self-checking bench for the pixel saturation boost.
// Depends on rsa_pkg and rgb_saturation_adjust; predicts each output pixel in
// exact integer arithmetic and checks the results in order.
module tb_rgb_saturation_adjust;

  // Watchdog: well over the slowest legal run of about 1150 items with full
  // gaps on both sides plus pipe latency, taken several times over.
  localparam int RUN_LIMIT   = 800000;
  localparam int PIPE_DEPTH  = 5;     // base of the drain margin at the end of the run
  localparam int PHASE_COUNT = 10;
  localparam int PHASE_ITEMS = 110;
  localparam int REPORT_MAX  = 10;
  localparam int PW          = rsa_pkg::PIX_W;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  rsa_pkg::in_item_t    in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  rsa_pkg::out_item_t   out_data;
  logic                 cfg_wr_en = 1'b0;
  logic [PW-1:0]        cfg_wr_data = '0;

  // Bench copy of the increment register, as the block should hold it.
  logic signed [PW-1:0] boost_level = '0;
  // Predicted pixels, oldest first.
  rsa_pkg::out_item_t   pixel_q [$];
  int                   mismatch_count = 0;
  int                   stall_left = 0;
  // Set to run both sides flat out, with no gaps and no stalls.
  bit                   steady = 1'b0;

  rgb_saturation_adjust dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Expected output pixel for a given increment. Everything is kept as an
  // exact ratio num/den, so one floor division per channel suffices.
  function automatic rsa_pkg::out_item_t predict_boost(input rsa_pkg::in_item_t px,
                                                       input logic signed [PW-1:0] inc);
    int ch [3];
    int adj [3];
    int hi, lo, spread, lsum, span_m, num, den, acc, i;
    rsa_pkg::out_item_t r;
    ch[0] = px.channel_a_in;
    ch[1] = px.channel_b_in;
    ch[2] = px.channel_c_in;
    hi = ch[0];
    lo = ch[0];
    for (i = 1; i < 3; i++) begin
      if (ch[i] > hi) hi = ch[i];
      if (ch[i] < lo) lo = ch[i];
    end
    spread = hi - lo;
    lsum   = hi + lo;
    span_m = (lsum < rsa_pkg::L_SPAN - lsum) ? lsum : rsa_pkg::L_SPAN - lsum;
    if (inc <= 0 || spread == 0) begin
      // no boost, or a gray pixel: straight through
      for (i = 0; i < 3; i++) adj[i] = ch[i];
    end else begin
      // at 100 and above the first branch always wins, so den never hits 0
      if (rsa_pkg::SAT_FULL * spread >= (rsa_pkg::SAT_FULL - int'(inc)) * span_m) begin
        num = span_m - spread;
        den = spread;
      end else begin
        num = int'(inc);
        den = rsa_pkg::SAT_FULL - int'(inc);
      end
      for (i = 0; i < 3; i++) begin
        acc = 2 * den * ch[i] + (2 * ch[i] - lsum) * num;
        if (acc < 0) begin
          adj[i] = 0;
        end else begin
          adj[i] = acc / (2 * den);
          if (adj[i] > 255) adj[i] = 255;
        end
      end
    end
    r.channel_a_out = PW'(adj[0]);
    r.channel_b_out = PW'(adj[1]);
    r.channel_c_out = PW'(adj[2]);
    return r;
  endfunction

  // Random pixel: mostly uniform, plus near-gray pixels (which reach the
  // second branch at high increments) and pixels built from the extremes.
  function automatic rsa_pkg::in_item_t random_pixel();
    rsa_pkg::in_item_t px;
    int base, db, dc;
    case ($urandom_range(0, 5))
      0, 1, 2: px = rsa_pkg::in_item_t'($urandom);
      3, 4: begin
        base = $urandom_range(0, 255);
        db   = $urandom_range(0, 3);
        dc   = $urandom_range(0, 3);
        px.channel_a_in = PW'(base);
        px.channel_b_in = PW'((base + db > 255) ? 255 : base + db);
        px.channel_c_in = PW'((base - dc < 0) ? 0 : base - dc);
      end
      default: begin
        px.channel_a_in = $urandom_range(0, 1) ? 8'hff : 8'h00;
        px.channel_b_in = $urandom_range(0, 1) ? 8'hff : PW'($urandom);
        px.channel_c_in = $urandom_range(0, 1) ? 8'h00 : PW'($urandom);
      end
    endcase
    return px;
  endfunction

  // Offer one pixel after a random gap and hold it until accepted. in_valid
  // is left high afterwards so back-to-back items never drop it.
  task automatic send_pixel(input rsa_pkg::in_item_t px);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= px;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pixel_q.push_back(predict_boost(px, boost_level));
  endtask

  // Hold off the sender until every predicted pixel has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
  endtask

  // Register writes only with the pipe empty.
  task automatic set_boost(input logic signed [PW-1:0] level);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= level;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    boost_level = level;
  endtask

  // Out of reset the increment is zero: every pixel passes unchanged.
  task automatic test_passthrough_at_reset();
    send_pixel('{8'h00, 8'h00, 8'h00});
    send_pixel('{8'hff, 8'hff, 8'hff});
    send_pixel('{8'hff, 8'h00, 8'h80});
    send_pixel('{8'h55, 8'haa, 8'h0f});
  endtask

  // Mid-range increment across gray, primaries and mixed colours.
  task automatic test_directed_boost();
    set_boost(8'sd60);
    send_pixel('{8'h00, 8'h00, 8'h00});
    send_pixel('{8'hff, 8'hff, 8'hff});
    send_pixel('{8'h80, 8'h80, 8'h80});
    send_pixel('{8'hff, 8'h00, 8'h00});
    send_pixel('{8'h00, 8'hff, 8'h00});
    send_pixel('{8'h00, 8'h00, 8'hff});
    send_pixel('{8'd200, 8'd100, 8'd50});
    send_pixel('{8'd10, 8'd5, 8'd0});
    send_pixel('{8'd250, 8'd240, 8'd245});
    send_pixel('{8'hff, 8'h01, 8'h00});
  endtask

  // Full strength, values above full scale, negative extremes and a
  // near-gray pixel that takes the inc/(100-inc) factor.
  task automatic test_strength_extremes();
    set_boost(8'sd100);
    send_pixel('{8'd200, 8'd100, 8'd50});
    send_pixel('{8'd128, 8'd127, 8'd127});
    set_boost(8'sd127);
    send_pixel('{8'd30, 8'd220, 8'd90});
    send_pixel('{8'd128, 8'd127, 8'd127});
    set_boost(-8'sd128);
    send_pixel('{8'hff, 8'h00, 8'h80});
    set_boost(-8'sd100);
    send_pixel('{8'd30, 8'd220, 8'd90});
    set_boost(8'sd99);
    send_pixel('{8'd128, 8'd127, 8'd127});
    send_pixel('{8'd3, 8'd2, 8'd2});
  endtask

  // Random phases, each with its own increment, a mix of flat-out and gappy
  // traffic, and one mid-phase pause until the pipe is empty.
  task automatic test_random_phases();
    int p, k, pause_at;
    logic signed [PW-1:0] level;
    for (p = 0; p < PHASE_COUNT; p++) begin
      case ($urandom_range(0, 5))
        0: level = -8'sd128;
        1: level = -8'sd100;
        2: level = ($urandom_range(0, 1)) ? 8'sd0 : 8'sd1;
        3: level = ($urandom_range(0, 1)) ? 8'sd100 : 8'sd127;
        default: level = PW'($urandom_range(1, 99));
      endcase
      // make sure the extremes and a negative value always show up
      if (p == 0) level = 8'sd1;
      if (p == 1) level = 8'sd99;
      if (p == 2) level = -8'sd1;
      set_boost(level);
      steady   = (p % 3 == 0);
      pause_at = $urandom_range(10, PHASE_ITEMS - 10);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 39) == 0) steady = !steady;
        if (k == pause_at) wait_drained();
        send_pixel(random_pixel());
      end
    end
    steady = 1'b0;
  endtask

  // Output side: check each accepted pixel against the oldest prediction,
  // then stall for a random number of cycles before taking the next one.
  always @(posedge clk) begin
    int hold;
    rsa_pkg::out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pixel_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("unexpected pixel: got %0d %0d %0d", out_data.channel_a_out,
                     out_data.channel_b_out, out_data.channel_c_out);
        end else begin
          want = pixel_q.pop_front();
          if (out_data.channel_a_out != want.channel_a_out ||
              out_data.channel_b_out != want.channel_b_out ||
              out_data.channel_c_out != want.channel_c_out) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
              $display("pixel mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                       want.channel_a_out, want.channel_b_out, want.channel_c_out,
                       out_data.channel_a_out, out_data.channel_b_out,
                       out_data.channel_c_out);
          end
        end
        hold = steady ? 0 : $urandom_range(0, 19);
        stall_left <= hold;
        out_stall  <= (hold != 0);
      end else if (stall_left > 1) begin
        stall_left <= stall_left - 1;
      end else begin
        stall_left <= 0;
        out_stall  <= 1'b0;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_passthrough_at_reset();
    test_directed_boost();
    test_strength_extremes();
    test_random_phases();
    wait_drained();
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    if (mismatch_count == 0 && pixel_q.size() == 0) begin
      $display("rgb_saturation_adjust verification clean");
    end else begin
      $display("rgb_saturation_adjust verification failed");
    end
    $finish;
  end

  initial begin
    #RUN_LIMIT;
    $display("rgb_saturation_adjust verification failed");
    $finish;
  end

endmodule
